[design/lru_block_cache_with_spill_top_defines.svh]
// Assertion macros for the LRU tile cache checker.
// Used by lbc_checker; no other dependencies.
`ifndef LRU_BLOCK_CACHE_WITH_SPILL_TOP_DEFINES_SVH
`define LRU_BLOCK_CACHE_WITH_SPILL_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define LBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define LBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lbc_pkg.sv]
// Shared types and constants for the LRU tile cache.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbc_pkg;

    // Tile store depth; field widths below are sized for it
    localparam int MAX_TILES = 1024;

    localparam int COORD_W = 10;
    localparam int CFG_W   = 11;
    localparam int SLOT_W  = 10;
    localparam int TILE_W  = 10;
    localparam int KIND_W  = 2;
    localparam int RES_W   = 11;
    localparam int CIDX_W  = 2;
    localparam int IDXF_W  = 22;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_BLOCKS_PER_ROW    = 2'd0;
    localparam logic [CIDX_W-1:0] REG_BLOCKS_PER_COLUMN = 2'd1;
    localparam logic [CIDX_W-1:0] REG_MAX_RESIDENT      = 2'd2;

    // Access kinds
    localparam logic [KIND_W-1:0] ACC_HIT    = 2'd0;
    localparam logic [KIND_W-1:0] ACC_FRESH  = 2'd1;
    localparam logic [KIND_W-1:0] ACC_REFILL = 2'd2;

    // Eviction kinds
    localparam logic [KIND_W-1:0] EVK_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] EVK_CLEAN = 2'd1;
    localparam logic [KIND_W-1:0] EVK_DIRTY = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] tile_x;
        logic [COORD_W-1:0] tile_y;
        logic               for_update;
    } req_t;

    typedef struct packed {
        logic               in_range;
        logic [KIND_W-1:0]  access_kind;
        logic [TILE_W-1:0]  tile_index;
        logic [SLOT_W-1:0]  fill_slot;
        logic [KIND_W-1:0]  evict_kind;
        logic [TILE_W-1:0]  evict_tile;
        logic [SLOT_W-1:0]  evict_slot;
        logic [RES_W-1:0]   resident_tiles;
    } rsp_t;

    // Per-tile status word
    typedef struct packed {
        logic              resident;
        logic              dirty;
        logic              spilled;
        logic [SLOT_W-1:0] slot;
    } meta_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic mul;
        logic look;
        logic push;
        logic rd_tail;
        logic evict;
        logic clr;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_range;
        logic evict_need;
        logic clr_last;
    } status_t;

endpackage

`default_nettype wire

[design/lru_block_cache_with_spill_top.sv]
// Top level of the LRU write-back tile cache with spill store.
// Depends on lbc_pkg, lbc_ctrl, lbc_dpath (and lbc_ram through it).
//
//  channel   signals                           carries
//  in        in_valid / in_ready / in_data     tile request (x, y, for_update)
//  out       out_valid / out_ready / out_data  residency and eviction report
//  cfg       cfg_wr_en / cfg_index / cfg_data  grid size and residency limit
//
// A transaction runs index multiply, status read, lookup, head push, tail read
// and, over the limit, LRU tail eviction; out of range it skips to the result.
// The single read port of the status RAMs sets these steps. After reset all
// MAX_TILES entries are cleared before a request is taken. The result sits in
// an output register, so the next request is taken while it awaits out_ready.
`timescale 1ns / 1ps
`default_nettype none

module lru_block_cache_with_spill_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [lbc_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [lbc_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire lbc_pkg::req_t              in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output lbc_pkg::rsp_t                   out_data
);
    import lbc_pkg::*;

    cmd_t    cmd;
    status_t st;

    lbc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .st(st), .cmd(cmd)
    );

    lbc_dpath u_dpath (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_data(in_data), .cmd(cmd), .st(st), .out_data(out_data)
    );

endmodule

`default_nettype wire

[design/lbc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

[design/lbc_ctrl.sv]
// Sequencing state machine for the LRU tile cache.
// Depends on lbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire lbc_pkg::status_t st,
    output lbc_pkg::cmd_t         cmd
);
    import lbc_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MUL, S_RD, S_LOOK, S_PUSH, S_ERD, S_EVICT, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = st.in_range ? S_LOOK : S_DONE;
            end
            S_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_ERD;
            end
            S_ERD:
            begin
                cmd.rd_tail = 1'b1;
                state_next  = st.evict_need ? S_EVICT : S_DONE;
            end
            S_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[design/lbc_dpath.sv]
// Datapath: config registers, LRU list links, tile status RAMs, result register.
// Depends on lbc_pkg and lbc_ram.
`timescale 1ns / 1ps
`default_nettype none

module lbc_dpath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [lbc_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [lbc_pkg::CFG_W-1:0]  cfg_data,
    input  wire lbc_pkg::req_t              in_data,
    input  wire lbc_pkg::cmd_t              cmd,
    output lbc_pkg::status_t                st,
    output lbc_pkg::rsp_t                   out_data
);
    import lbc_pkg::*;

    localparam int IW = $clog2(MAX_TILES);
    localparam int LW = $clog2(MAX_TILES + 1);
    localparam logic [LW-1:0] NIL = LW'(MAX_TILES);
    localparam int MW = $bits(meta_t);

    // Config registers
    logic [CFG_W-1:0] bpr_reg, bpc_reg, maxr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpr_reg  <= CFG_W'(1);
            bpc_reg  <= CFG_W'(1);
            maxr_reg <= CFG_W'(1);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BLOCKS_PER_ROW:    bpr_reg  <= cfg_data;
                REG_BLOCKS_PER_COLUMN: bpc_reg  <= cfg_data;
                REG_MAX_RESIDENT:      maxr_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Request and result registers (payload)
    req_t              req_reg;
    logic [IDXF_W-1:0] idxf_reg;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [SLOT_W-1:0] fslot_reg, fslot_next;
    logic [KIND_W-1:0] ekind_reg, ekind_next;
    logic [TILE_W-1:0] etile_reg, etile_next;
    logic [SLOT_W-1:0] eslot_reg, eslot_next;
    rsp_t              out_reg;

    // Control state
    logic [LW-1:0]    head_reg, head_next;
    logic [LW-1:0]    tail_reg, tail_next;
    logic [LW-1:0]    count_reg, count_next;
    logic [CFG_W-1:0] nfs_reg, nfs_next;
    logic [IW-1:0]    clr_reg;

    // RAM ports
    logic          meta_we, prev_we, next_we;
    logic [IW-1:0] meta_wa, prev_wa, next_wa;
    meta_t         meta_wd, meta_rd;
    logic [LW-1:0] prev_wd, next_wd, prev_rd, next_rd;
    logic [IW-1:0] rd_addr, idx;
    logic [MW-1:0] meta_rd_raw;

    lbc_ram #(.WIDTH(MW), .DEPTH(MAX_TILES)) u_meta_ram (
        .clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
        .raddr(rd_addr), .rdata(meta_rd_raw)
    );
    lbc_ram #(.WIDTH(LW), .DEPTH(MAX_TILES)) u_prev_ram (
        .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
        .raddr(rd_addr), .rdata(prev_rd)
    );
    lbc_ram #(.WIDTH(LW), .DEPTH(MAX_TILES)) u_next_ram (
        .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
        .raddr(idx), .rdata(next_rd)
    );

    assign meta_rd = meta_t'(meta_rd_raw);
    assign idx     = idxf_reg[IW-1:0];
    assign rd_addr = cmd.rd_tail ? tail_reg[IW-1:0] : idx;

    // Status toward the controller
    assign st.in_range = (CFG_W'(req_reg.tile_x) < bpr_reg)
                      && (CFG_W'(req_reg.tile_y) < bpc_reg)
                      && (idxf_reg < IDXF_W'(MAX_TILES));
    assign st.evict_need = 32'(count_reg) > 32'(maxr_reg);
    assign st.clr_last   = (32'(clr_reg) == MAX_TILES - 1);

    // List and status update
    logic [LW-1:0] p_lnk, n_lnk, pt_lnk;
    logic [SLOT_W-1:0] eslot_w;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        nfs_next   = nfs_reg;
        kind_next  = kind_reg;
        fslot_next = fslot_reg;
        ekind_next = ekind_reg;
        etile_next = etile_reg;
        eslot_next = eslot_reg;
        meta_we = 1'b0; meta_wa = idx; meta_wd = '0;
        prev_we = 1'b0; prev_wa = idx; prev_wd = '0;
        next_we = 1'b0; next_wa = idx; next_wd = '0;
        p_lnk   = (LW'(idx) == head_reg) ? NIL : prev_rd;
        n_lnk   = (LW'(idx) == tail_reg) ? NIL : next_rd;
        pt_lnk  = (tail_reg == head_reg) ? NIL : prev_rd;
        eslot_w = meta_rd.spilled ? meta_rd.slot : nfs_reg[SLOT_W-1:0];

        if (cmd.clr)
        begin
            meta_we = 1'b1;
            meta_wa = clr_reg;
        end

        if (cmd.mul)
        begin
            kind_next  = ACC_HIT;
            fslot_next = '0;
            ekind_next = EVK_NONE;
            etile_next = '0;
            eslot_next = '0;
        end

        // Lookup: unlink a hit, or count a new resident
        if (cmd.look)
        begin
            if (meta_rd.resident)
            begin
                kind_next = ACC_HIT;
                if (p_lnk != NIL && n_lnk != NIL)
                begin
                    next_we = 1'b1; next_wa = p_lnk[IW-1:0]; next_wd = n_lnk;
                    prev_we = 1'b1; prev_wa = n_lnk[IW-1:0]; prev_wd = p_lnk;
                end
                if (p_lnk == NIL)
                begin
                    head_next = n_lnk;
                end
                if (n_lnk == NIL)
                begin
                    tail_next = p_lnk;
                end
            end
            else
            begin
                kind_next  = meta_rd.spilled ? ACC_REFILL : ACC_FRESH;
                fslot_next = meta_rd.spilled ? meta_rd.slot : '0;
                count_next = count_reg + LW'(1);
            end
            meta_we = 1'b1;
            meta_wd = '{resident: 1'b1, dirty: meta_rd.dirty | req_reg.for_update,
                        spilled: meta_rd.spilled, slot: meta_rd.slot};
        end

        // Push at head
        if (cmd.push)
        begin
            next_we = 1'b1; next_wa = idx; next_wd = head_reg;
            if (head_reg != NIL)
            begin
                prev_we = 1'b1; prev_wa = head_reg[IW-1:0]; prev_wd = LW'(idx);
            end
            head_next = LW'(idx);
            if (tail_reg == NIL)
            begin
                tail_next = LW'(idx);
            end
        end

        // Evict the tail
        if (cmd.evict)
        begin
            tail_next = pt_lnk;
            if (pt_lnk == NIL)
            begin
                head_next = NIL;
            end
            etile_next = TILE_W'(tail_reg[IW-1:0]);
            count_next = count_reg - LW'(1);
            meta_we    = 1'b1;
            meta_wa    = tail_reg[IW-1:0];
            if (meta_rd.dirty)
            begin
                ekind_next = EVK_DIRTY;
                eslot_next = eslot_w;
                if (!meta_rd.spilled)
                begin
                    nfs_next = nfs_reg + CFG_W'(1);
                end
                meta_wd = '{resident: 1'b0, dirty: 1'b0, spilled: 1'b1, slot: eslot_w};
            end
            else
            begin
                ekind_next = EVK_CLEAN;
                meta_wd = '{resident: 1'b0, dirty: 1'b0, spilled: meta_rd.spilled,
                            slot: meta_rd.slot};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= NIL;
            tail_reg  <= NIL;
            count_reg <= '0;
            nfs_reg   <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            nfs_reg   <= nfs_next;
            if (cmd.clr)
            begin
                clr_reg <= clr_reg + IW'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= in_data;
        end
        if (cmd.mul)
        begin
            idxf_reg <= IDXF_W'(req_reg.tile_x)
                      + (IDXF_W'(req_reg.tile_y) * IDXF_W'(bpr_reg));
        end
        kind_reg  <= kind_next;
        fslot_reg <= fslot_next;
        ekind_reg <= ekind_next;
        etile_reg <= etile_next;
        eslot_reg <= eslot_next;
        if (cmd.load_out)
        begin
            out_reg.in_range       <= st.in_range;
            out_reg.access_kind    <= st.in_range ? kind_reg : ACC_HIT;
            out_reg.tile_index     <= st.in_range ? idxf_reg[TILE_W-1:0] : '0;
            out_reg.fill_slot      <= st.in_range ? fslot_reg : '0;
            out_reg.evict_kind     <= st.in_range ? ekind_reg : EVK_NONE;
            out_reg.evict_tile     <= st.in_range ? etile_reg : '0;
            out_reg.evict_slot     <= st.in_range ? eslot_reg : '0;
            out_reg.resident_tiles <= RES_W'(count_reg);
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

[design/lbc_checker.sv]
// Port-level checks for the LRU tile cache, bound to the top level.
// Depends on lbc_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_block_cache_with_spill_top_defines.svh"

module lbc_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          out_valid,
    input wire logic          out_ready,
    input wire lbc_pkg::rsp_t out_data
);
    import lbc_pkg::*;

    // A stalled result holds
    `LBC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

    // Out-of-range reports carry nothing but the count
    `LBC_ASSERT_IMP(a_oor_zero, out_valid && !out_data.in_range, out_data.access_kind == ACC_HIT && out_data.evict_kind == EVK_NONE && out_data.tile_index == '0 && out_data.evict_tile == '0, "out-of-range report not cleared")

    // Fill slot only on a refill
    `LBC_ASSERT_IMP(a_fill_slot, out_valid && out_data.access_kind != ACC_REFILL, out_data.fill_slot == '0, "fill slot without refill")

    // Evict slot only on a dirty eviction
    `LBC_ASSERT_IMP(a_evict_slot, out_valid && out_data.evict_kind != EVK_DIRTY, out_data.evict_slot == '0, "evict slot without write-back")

endmodule

bind lru_block_cache_with_spill_top lbc_checker u_lbc_checker (.*);

`default_nettype wire
